/* sv/sorted_breakpoint_table_interp_macros.svh */
// Assertion macros shared by the breakpoint table RTL.
`ifndef SORTED_BREAKPOINT_TABLE_INTERP_MACROS_SVH
`define SORTED_BREAKPOINT_TABLE_INTERP_MACROS_SVH

`define SBTI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sbti: same-cycle check failed");

`define SBTI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sbti: next-cycle check failed");

`endif

/* sv/sbti_pkg.sv */
// Package: types, codes and helpers of the breakpoint table.
`default_nettype none
package sbti_pkg;
	localparam int MAX_POINTS_DEF = 256;
	localparam int MUL_W = 34;
	localparam int MUL_STEPS = 34;
	localparam int DIV_STEPS = 64;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_VALUE  = 2'd1;
	localparam logic [1:0] MODE_AREA   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DUP   = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	typedef struct packed {
		logic [1:0]         mode;
		logic [31:0]        point_time;
		logic signed [31:0] point_value;
		logic [31:0]        end_time;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] interp_value;
		logic signed [63:0] area_result;
		logic [8:0]         points_held;
	} rsp_t;

	typedef struct packed {
		logic [31:0] ptime;
		logic [31:0] pvalue;
	} point_t;

	typedef struct packed {
		logic             start;
		logic             op;
		logic [63:0]      a;
		logic [MUL_W-1:0] b;
	} arith_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} arith_rsp_t;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		begin
			s = {a[63], a} + {b[63], b};
			if (s[64] != s[63])
				sat_add = s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
			else
				sat_add = s[63:0];
		end
	endfunction
endpackage
`default_nettype wire

/* sv/sbti_if.sv */
// Request and response channel interfaces of the breakpoint table.
`default_nettype none
interface sbti_req_if;
	import sbti_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface sbti_rsp_if;
	import sbti_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/sbti_arith.sv */
// Shared serial unit: shift-add multiplier and restoring divider.
`default_nettype none
module sbti_arith (
	input  wire                  clk,
	input  wire                  arst_n,
	input  sbti_pkg::arith_req_t areq,
	output sbti_pkg::arith_rsp_t arsp
);
	import sbti_pkg::*;

	logic             busy_q;
	logic             op_q;
	logic             done_q;
	logic [6:0]       cnt_q;
	logic [63:0]      acc_q;
	logic [63:0]      mc_q;
	logic [MUL_W-1:0] mp_q;
	logic [32:0]      rem_q;

	logic [32:0] remx;
	logic        rem_ge;
	logic        last;

	always_comb begin
		remx = {rem_q[31:0], mc_q[63]};
		rem_ge = remx >= {1'b0, mp_q[31:0]};
		last = (op_q == OP_MUL) ? (cnt_q == 7'(MUL_STEPS - 1)) : (cnt_q == 7'(DIV_STEPS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (areq.start) begin
				busy_q <= 1'b1;
				op_q <= areq.op;
				cnt_q <= '0;
				acc_q <= '0;
				mc_q <= areq.a;
				mp_q <= areq.b;
				rem_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (op_q == OP_MUL) begin
					if (mp_q[0])
						acc_q <= acc_q + mc_q;
					mc_q <= {mc_q[62:0], 1'b0};
					mp_q <= {1'b0, mp_q[MUL_W-1:1]};
				end else begin
					mc_q <= {mc_q[62:0], 1'b0};
					rem_q <= rem_ge ? (remx - {1'b0, mp_q[31:0]}) : remx;
					acc_q <= {acc_q[62:0], rem_ge};
				end
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign arsp.done = done_q;
	assign arsp.result = acc_q;
endmodule
`default_nettype wire

/* sv/sbti_store.sv */
// Breakpoint memory: one write port, one registered read port.
`default_nettype none
module sbti_store #(
	parameter int DEPTH = sbti_pkg::MAX_POINTS_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire              clk,
	input  wire              we,
	input  wire [AW-1:0]     waddr,
	input  sbti_pkg::point_t wdata,
	input  wire [AW-1:0]     raddr,
	output sbti_pkg::point_t rdata
);
	import sbti_pkg::*;

	point_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* sv/sorted_breakpoint_table_interp.sv */
// Top level: sequencer of the sorted breakpoint table with interpolation and area.
// Insert: binary search, then points above the slot shift up via the single read port.
// Value: binary search for the segment, then a 34-step multiply and a 64-step divide.
// Area: two value queries and a multiply per spanned segment, or one flat multiply.
// One request at a time; the response register frees the sequencer before it is taken.
// Reset clears the point count and the response valid; table contents are left as they are.
`default_nettype none
`include "sorted_breakpoint_table_interp_macros.svh"
module sorted_breakpoint_table_interp #(
	parameter int MAX_POINTS = sbti_pkg::MAX_POINTS_DEF
) (
	input wire         clk,
	input wire         arst_n,
	sbti_req_if.sink   req,
	sbti_rsp_if.source rsp
);
	import sbti_pkg::*;

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int IW = $clog2(MAX_POINTS + 2);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int RW = IW + 2;

	localparam logic [5:0] S_IDLE      = 6'd0;
	localparam logic [5:0] S_INS_SRCH  = 6'd1;
	localparam logic [5:0] S_INS_CMP   = 6'd2;
	localparam logic [5:0] S_INS_DUP   = 6'd3;
	localparam logic [5:0] S_INS_DCHK  = 6'd4;
	localparam logic [5:0] S_INS_FULL  = 6'd5;
	localparam logic [5:0] S_INS_SHIFT = 6'd6;
	localparam logic [5:0] S_INS_MOVE  = 6'd7;
	localparam logic [5:0] S_RD_FIRST  = 6'd8;
	localparam logic [5:0] S_RD_LAST   = 6'd9;
	localparam logic [5:0] S_VAL       = 6'd10;
	localparam logic [5:0] S_SRCH      = 6'd11;
	localparam logic [5:0] S_SRCH_CMP  = 6'd12;
	localparam logic [5:0] S_VAL_RL    = 6'd13;
	localparam logic [5:0] S_VAL_RR    = 6'd14;
	localparam logic [5:0] S_VAL_CALC  = 6'd15;
	localparam logic [5:0] S_VAL_MUL   = 6'd16;
	localparam logic [5:0] S_VAL_DIV   = 6'd17;
	localparam logic [5:0] S_V_DONE    = 6'd18;
	localparam logic [5:0] S_A_START   = 6'd19;
	localparam logic [5:0] S_A_IMIN    = 6'd20;
	localparam logic [5:0] S_A_HIGH    = 6'd21;
	localparam logic [5:0] S_A_IMAX    = 6'd22;
	localparam logic [5:0] S_A_VMIN    = 6'd23;
	localparam logic [5:0] S_A_VMAX    = 6'd24;
	localparam logic [5:0] S_A_WALK    = 6'd25;
	localparam logic [5:0] S_W_TOP     = 6'd26;
	localparam logic [5:0] S_W_RD      = 6'd27;
	localparam logic [5:0] S_W_MUL0    = 6'd28;
	localparam logic [5:0] S_W_MUL     = 6'd29;
	localparam logic [5:0] S_A_FINAL   = 6'd30;
	localparam logic [5:0] S_A_ADJ     = 6'd31;
	localparam logic [5:0] S_C_START   = 6'd32;
	localparam logic [5:0] S_C_MUL     = 6'd33;
	localparam logic [5:0] S_FIN       = 6'd34;

	logic [5:0]    state_q, vret_q, sret_q;
	logic [CW-1:0] n_q;
	logic [IW-1:0] lo_q, hi_q, mid_q, i_q, imin_q, imax_q;
	logic [1:0]    mode_q;
	logic [31:0]   t0_q, val_q, t1_q;
	logic [31:0]   ft_q, fv_q, lt_q, lv_q;
	logic [31:0]   qt_q;
	logic          low_q;
	logic [31:0]   tl_q, vl_q, span_q, fres_q, fmin_q, fmax_q, cv_q;
	logic          diffneg_q, neg_q;
	logic [31:0]   wt_q, wf_q, tr_q, fr_q;
	logic [63:0]   qsum_q, area_q;
	logic [RW-1:0] rsum_q;
	logic [1:0]    st_q;
	logic [31:0]   iv_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic          we;
	logic [AW-1:0] ra, wa;
	point_t        wd, rd;
	arith_req_t    areq;
	arith_rsp_t    arsp;

	logic [IW-1:0] nx;
	logic [CW-1:0] nm1;
	logic [IW:0]   mid_sum;
	logic [IW-1:0] mid_c, midm1, lom1, im1;
	logic          srch_go;
	logic [32:0]   diff33, dmag33;
	logic [31:0]   qdt;
	logic [32:0]   s33, smag, d33, dmagw, dt33, dtmag;
	logic [31:0]   cvmag;
	logic [32:0]   v33, vres33;
	logic [63:0]   qv, qadd;
	logic [RW-1:0] radd, rs_adj;
	logic [63:0]   half64;
	logic          load_rsp;
	logic          arith_wait;

	assign nx = IW'(n_q);
	assign nm1 = n_q - 1'b1;
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_c = mid_sum[IW:1];
	assign midm1 = mid_c - 1'b1;
	assign lom1 = lo_q - 1'b1;
	assign im1 = i_q - 1'b1;
	assign srch_go = {1'b0, hi_q} > ({1'b0, lo_q} + 1'b1);

	assign diff33 = {rd.pvalue[31], rd.pvalue} - {vl_q[31], vl_q};
	assign dmag33 = diff33[32] ? (33'd0 - diff33) : diff33;
	assign qdt = qt_q - tl_q;
	assign v33 = {vl_q[31], vl_q};
	assign vres33 = diffneg_q ? (v33 - arsp.result[32:0]) : (v33 + arsp.result[32:0]);

	assign s33 = {wf_q[31], wf_q} + {fr_q[31], fr_q};
	assign smag = s33[32] ? (33'd0 - s33) : s33;
	assign d33 = {1'b0, tr_q} - {1'b0, wt_q};
	assign dmagw = d33[32] ? (33'd0 - d33) : d33;
	assign qv = {1'b0, arsp.result[63:1]};
	assign qadd = neg_q ? (64'd0 - qv) : qv;
	assign radd = arsp.result[0] ? (neg_q ? {RW{1'b1}} : RW'(1)) : '0;
	assign rs_adj = rsum_q + RW'(rsum_q[RW-1]);
	assign half64 = {{(64 - RW + 1){rs_adj[RW-1]}}, rs_adj[RW-1:1]};

	assign dt33 = {1'b0, t1_q} - {1'b0, t0_q};
	assign dtmag = dt33[32] ? (33'd0 - dt33) : dt33;
	assign cvmag = cv_q[31] ? (32'd0 - cv_q) : cv_q;

	assign load_rsp = (state_q == S_FIN) && (!rsp_valid_q || rsp.ready);
	assign arith_wait = (state_q == S_VAL_MUL) || (state_q == S_VAL_DIV) ||
		(state_q == S_W_MUL) || (state_q == S_C_MUL);

	always_comb begin
		ra = '0;
		we = 1'b0;
		wa = '0;
		wd = rd;
		areq = '{start: 1'b0, op: OP_MUL, a: '0, b: '0};
		unique case (state_q)
			S_INS_SRCH: ra = mid_c[AW-1:0];
			S_INS_DUP: ra = lo_q[AW-1:0];
			S_INS_SHIFT: begin
				ra = im1[AW-1:0];
				if (i_q <= lo_q) begin
					we = 1'b1;
					wa = lo_q[AW-1:0];
					wd = '{ptime: t0_q, pvalue: val_q};
				end
			end
			S_INS_MOVE: begin
				we = 1'b1;
				wa = i_q[AW-1:0];
			end
			S_RD_FIRST: ra = nm1[AW-1:0];
			S_SRCH: ra = midm1[AW-1:0];
			S_VAL_RL: ra = lom1[AW-1:0];
			S_VAL_RR: ra = lo_q[AW-1:0];
			S_VAL_CALC: areq = '{start: 1'b1, op: OP_MUL, a: 64'(dmag33), b: {2'b00, qdt}};
			S_VAL_MUL: begin
				if (arsp.done)
					areq = '{start: 1'b1, op: OP_DIV, a: arsp.result, b: {2'b00, span_q}};
			end
			S_W_TOP: ra = i_q[AW-1:0];
			S_W_MUL0: areq = '{start: 1'b1, op: OP_MUL, a: 64'(smag), b: {1'b0, dmagw}};
			S_C_START: areq = '{start: 1'b1, op: OP_MUL, a: 64'(dtmag), b: {2'b00, cvmag}};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
				rsp_q <= '{status: st_q, interp_value: iv_q, area_result: area_q,
					points_held: 9'(n_q)};
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						mode_q <= req.data.mode;
						t0_q <= req.data.point_time;
						val_q <= req.data.point_value;
						t1_q <= req.data.end_time;
						st_q <= ST_OK;
						iv_q <= '0;
						area_q <= '0;
						lo_q <= '0;
						hi_q <= nx;
						if (req.data.mode == MODE_INSERT) begin
							state_q <= S_INS_SRCH;
						end else if (req.data.mode == MODE_VALUE || req.data.mode == MODE_AREA) begin
							if (n_q == '0) begin
								st_q <= ST_EMPTY;
								state_q <= S_FIN;
							end else begin
								state_q <= S_RD_FIRST;
							end
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_INS_SRCH: begin
					if (lo_q < hi_q) begin
						mid_q <= mid_c;
						state_q <= S_INS_CMP;
					end else begin
						state_q <= S_INS_DUP;
					end
				end
				S_INS_CMP: begin
					if (rd.ptime < t0_q)
						lo_q <= mid_q + 1'b1;
					else
						hi_q <= mid_q;
					state_q <= S_INS_SRCH;
				end
				S_INS_DUP: state_q <= (lo_q < nx) ? S_INS_DCHK : S_INS_FULL;
				S_INS_DCHK: begin
					if (rd.ptime == t0_q) begin
						st_q <= ST_DUP;
						state_q <= S_FIN;
					end else begin
						state_q <= S_INS_FULL;
					end
				end
				S_INS_FULL: begin
					if (nx >= IW'(MAX_POINTS)) begin
						st_q <= ST_FULL;
						state_q <= S_FIN;
					end else begin
						i_q <= nx;
						state_q <= S_INS_SHIFT;
					end
				end
				S_INS_SHIFT: begin
					if (i_q > lo_q) begin
						state_q <= S_INS_MOVE;
					end else begin
						n_q <= n_q + 1'b1;
						state_q <= S_FIN;
					end
				end
				S_INS_MOVE: begin
					i_q <= im1;
					state_q <= S_INS_SHIFT;
				end
				S_RD_FIRST: begin
					ft_q <= rd.ptime;
					fv_q <= rd.pvalue;
					state_q <= S_RD_LAST;
				end
				S_RD_LAST: begin
					lt_q <= rd.ptime;
					lv_q <= rd.pvalue;
					qt_q <= t0_q;
					vret_q <= S_V_DONE;
					state_q <= (mode_q == MODE_VALUE) ? S_VAL : S_A_START;
				end
				S_VAL: begin
					if (qt_q <= ft_q) begin
						fres_q <= fv_q;
						state_q <= vret_q;
					end else if (qt_q >= lt_q) begin
						fres_q <= lv_q;
						state_q <= vret_q;
					end else begin
						lo_q <= IW'(1);
						hi_q <= nx;
						low_q <= 1'b1;
						sret_q <= S_VAL_RL;
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (srch_go) begin
						mid_q <= mid_c;
						state_q <= S_SRCH_CMP;
					end else begin
						state_q <= sret_q;
					end
				end
				S_SRCH_CMP: begin
					if (low_q ? (qt_q < rd.ptime) : (qt_q <= rd.ptime))
						hi_q <= mid_q;
					else
						lo_q <= mid_q;
					state_q <= S_SRCH;
				end
				S_VAL_RL: state_q <= S_VAL_RR;
				S_VAL_RR: begin
					tl_q <= rd.ptime;
					vl_q <= rd.pvalue;
					state_q <= S_VAL_CALC;
				end
				S_VAL_CALC: begin
					span_q <= rd.ptime - tl_q;
					diffneg_q <= diff33[32];
					state_q <= S_VAL_MUL;
				end
				S_VAL_MUL: begin
					if (arsp.done)
						state_q <= S_VAL_DIV;
				end
				S_VAL_DIV: begin
					if (arsp.done) begin
						fres_q <= vres33[31:0];
						state_q <= vret_q;
					end
				end
				S_V_DONE: begin
					iv_q <= fres_q;
					state_q <= S_FIN;
				end
				S_A_START: begin
					if (n_q == CW'(1)) begin
						cv_q <= fv_q;
						state_q <= S_C_START;
					end else if (t0_q < ft_q) begin
						imin_q <= '0;
						state_q <= S_A_HIGH;
					end else if (t0_q >= lt_q) begin
						cv_q <= lv_q;
						state_q <= S_C_START;
					end else begin
						qt_q <= t0_q;
						lo_q <= IW'(1);
						hi_q <= nx;
						low_q <= 1'b1;
						sret_q <= S_A_IMIN;
						state_q <= S_SRCH;
					end
				end
				S_A_IMIN: begin
					imin_q <= lo_q;
					state_q <= S_A_HIGH;
				end
				S_A_HIGH: begin
					if (t1_q <= ft_q) begin
						cv_q <= fv_q;
						state_q <= S_C_START;
					end else if (t1_q > lt_q) begin
						imax_q <= nx + 1'b1;
						state_q <= S_A_VMIN;
					end else begin
						qt_q <= t1_q;
						lo_q <= IW'(1);
						hi_q <= nx;
						low_q <= 1'b0;
						sret_q <= S_A_IMAX;
						state_q <= S_SRCH;
					end
				end
				S_A_IMAX: begin
					imax_q <= hi_q;
					state_q <= S_A_VMIN;
				end
				S_A_VMIN: begin
					qt_q <= t0_q;
					vret_q <= S_A_VMAX;
					state_q <= S_VAL;
				end
				S_A_VMAX: begin
					fmin_q <= fres_q;
					qt_q <= t1_q;
					vret_q <= S_A_WALK;
					state_q <= S_VAL;
				end
				S_A_WALK: begin
					fmax_q <= fres_q;
					i_q <= imin_q;
					wt_q <= t0_q;
					wf_q <= fmin_q;
					qsum_q <= '0;
					rsum_q <= '0;
					state_q <= S_W_TOP;
				end
				S_W_TOP: begin
					if (i_q < imax_q) begin
						if (i_q + 1'b1 == imax_q) begin
							tr_q <= t1_q;
							fr_q <= fmax_q;
							state_q <= S_W_MUL0;
						end else begin
							state_q <= S_W_RD;
						end
					end else begin
						state_q <= S_A_FINAL;
					end
				end
				S_W_RD: begin
					tr_q <= rd.ptime;
					fr_q <= rd.pvalue;
					state_q <= S_W_MUL0;
				end
				S_W_MUL0: begin
					neg_q <= s33[32] ^ d33[32];
					state_q <= S_W_MUL;
				end
				S_W_MUL: begin
					if (arsp.done) begin
						qsum_q <= sat_add(qsum_q, qadd);
						rsum_q <= rsum_q + radd;
						wt_q <= tr_q;
						wf_q <= fr_q;
						i_q <= i_q + 1'b1;
						state_q <= S_W_TOP;
					end
				end
				S_A_FINAL: begin
					area_q <= sat_add(qsum_q, half64);
					state_q <= S_A_ADJ;
				end
				S_A_ADJ: begin
					if (rsum_q[0] && !rsum_q[RW-1] && area_q[63])
						area_q <= sat_add(area_q, 64'd1);
					else if (rsum_q[0] && rsum_q[RW-1] && !area_q[63] && area_q != '0)
						area_q <= sat_add(area_q, {64{1'b1}});
					state_q <= S_FIN;
				end
				S_C_START: begin
					neg_q <= dt33[32] ^ cv_q[31];
					state_q <= S_C_MUL;
				end
				S_C_MUL: begin
					if (arsp.done) begin
						area_q <= neg_q ? (64'd0 - arsp.result) : arsp.result;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (load_rsp)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	sbti_store #(.DEPTH(MAX_POINTS), .AW(AW)) u_store (
		.clk(clk),
		.we(we),
		.waddr(wa),
		.wdata(wd),
		.raddr(ra),
		.rdata(rd)
	);

	sbti_arith u_arith (
		.clk(clk),
		.arst_n(arst_n),
		.areq(areq),
		.arsp(arsp)
	);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	`SBTI_ASSERT_NEXT(a_accept_busy, req.valid && req.ready, state_q != S_IDLE)
	`SBTI_ASSERT_NOW(a_count_cap, 1'b1, n_q <= CW'(MAX_POINTS))
	`SBTI_ASSERT_NOW(a_count_step, n_q != $past(n_q), n_q == $past(n_q) + 1'b1)
	`SBTI_ASSERT_NOW(a_done_wait, arsp.done, arith_wait)
endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Testbench of the sorted breakpoint table: directed rows, then random traffic checked by a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import sbti_pkg::*;

	localparam logic [1:0] MODE_IGNORED = 2'd3;
	localparam int TABLE_DEPTH = 256;
	localparam int RANDOM_ITEMS = 1500;
	localparam int IDLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 600;

	logic clk;
	logic arst_n;

	sbti_req_if req_if ();
	sbti_rsp_if rsp_if ();

	sorted_breakpoint_table_interp DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	bit [31:0] table_times [TABLE_DEPTH];
	int table_values [TABLE_DEPTH];
	int unsigned table_count;

	rsp_t expected_rsps [$];
	int mismatches = 0;
	int results_seen = 0;
	int idle_cycles = 0;

	typedef struct {
		req_t r;
		bit   typed;
		rsp_t e;
	} row_t;
	row_t rows [$];

	function automatic bit [31:0] t_at(int unsigned i);
		return table_times[(i - 1) % TABLE_DEPTH];
	endfunction

	function automatic longint v_at(int unsigned i);
		return table_values[(i - 1) % TABLE_DEPTH];
	endfunction

	function automatic longint unsigned mag(longint a);
		longint unsigned u;
		u = a;
		return a < 0 ? 64'd0 - u : u;
	endfunction

	function automatic longint sat_sum(longint a, longint b);
		if (b > 0 && a > 64'sh7FFF_FFFF_FFFF_FFFF - b) return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (b < 0 && a < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - b) return -64'sh7FFF_FFFF_FFFF_FFFF - 1;
		return a + b;
	endfunction

	function automatic int unsigned lower_slot(bit [31:0] t);
		int unsigned n, lo, hi, mid;
		n = table_count;
		lo = 1;
		hi = n;
		if (t < t_at(1)) return 0;
		if (t >= t_at(n)) return n;
		while (hi > lo + 1) begin
			mid = (lo + hi) / 2;
			if (t < t_at(mid)) hi = mid; else lo = mid;
		end
		return lo;
	endfunction

	function automatic int unsigned upper_slot(bit [31:0] t);
		int unsigned n, lo, hi, mid;
		n = table_count;
		lo = 1;
		hi = n;
		if (t <= t_at(1)) return 1;
		if (t > t_at(n)) return n + 1;
		while (hi > lo + 1) begin
			mid = (lo + hi) / 2;
			if (t <= t_at(mid)) hi = mid; else lo = mid;
		end
		return hi;
	endfunction

	function automatic longint level_at(bit [31:0] t);
		int unsigned n, il;
		bit [31:0] tl, tr, span;
		longint vl, vr, diff;
		longint unsigned q, off;
		n = table_count;
		if (t <= t_at(1)) return v_at(1);
		if (t >= t_at(n)) return v_at(n);
		il = lower_slot(t);
		tl = t_at(il);
		tr = t_at(il + 1);
		vl = v_at(il);
		vr = v_at(il + 1);
		if (t == tr) return vr;
		span = tr - tl;
		if (span == 0) return (vl + vr) / 2;
		diff = vr - vl;
		off = t - tl;
		q = (mag(diff) * off) / span;
		return diff < 0 ? vl - longint'(q) : vl + longint'(q);
	endfunction

	function automatic longint flat_area(longint dt, longint v);
		longint unsigned m;
		bit neg;
		m = mag(dt) * mag(v);
		neg = (dt < 0) != (v < 0);
		if (m > 64'h7FFF_FFFF_FFFF_FFFF)
			return neg ? -64'sh7FFF_FFFF_FFFF_FFFF - 1 : 64'sh7FFF_FFFF_FFFF_FFFF;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint area_between(bit [31:0] tmin, bit [31:0] tmax);
		int unsigned n, imin, imax;
		longint dt, qsum, rsum, a, lo_t, hi_t, tl, fl, tr, fr, s, d, q, r;
		longint unsigned m;
		n = table_count;
		lo_t = tmin;
		hi_t = tmax;
		dt = hi_t - lo_t;
		qsum = 0;
		rsum = 0;
		if (n == 1) return flat_area(dt, v_at(1));
		imin = lower_slot(tmin);
		if (imin == n) return flat_area(dt, v_at(n));
		imax = upper_slot(tmax);
		if (imax == 1) return flat_area(dt, v_at(1));
		for (int unsigned i = imin; i < imax; i++) begin
			if (i == imin) begin
				tl = lo_t;
				fl = level_at(tmin);
			end else begin
				tl = t_at(i);
				fl = v_at(i);
			end
			if (i + 1 == imax) begin
				tr = hi_t;
				fr = level_at(tmax);
			end else begin
				tr = t_at(i + 1);
				fr = v_at(i + 1);
			end
			s = fl + fr;
			d = tr - tl;
			m = mag(s) * mag(d);
			q = longint'(m >> 1);
			r = longint'(m & 64'd1);
			if ((s < 0) != (d < 0)) begin
				q = -q;
				r = -r;
			end
			qsum = sat_sum(qsum, q);
			rsum += r;
		end
		a = sat_sum(qsum, rsum / 2);
		if (rsum % 2 == 1 && a < 0) a = sat_sum(a, 1);
		if (rsum % 2 == -1 && a > 0) a = sat_sum(a, -1);
		return a;
	endfunction

	function automatic logic [1:0] add_point(bit [31:0] t, int v);
		int unsigned n, lo, hi, mid;
		n = table_count;
		lo = 0;
		hi = n;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (table_times[mid % TABLE_DEPTH] < t) lo = mid + 1; else hi = mid;
		end
		if (lo < n && table_times[lo % TABLE_DEPTH] == t) return ST_DUP;
		if (n >= TABLE_DEPTH) return ST_FULL;
		for (int unsigned i = n; i > lo; i--) begin
			table_times[i % TABLE_DEPTH] = table_times[(i - 1) % TABLE_DEPTH];
			table_values[i % TABLE_DEPTH] = table_values[(i - 1) % TABLE_DEPTH];
		end
		table_times[lo % TABLE_DEPTH] = t;
		table_values[lo % TABLE_DEPTH] = v;
		table_count = n + 1;
		return ST_OK;
	endfunction

	function automatic rsp_t predict_rsp(req_t r);
		rsp_t o;
		longint iv;
		o = '0;
		iv = 0;
		case (r.mode)
			MODE_INSERT: o.status = add_point(r.point_time, r.point_value);
			MODE_VALUE: begin
				if (table_count == 0) o.status = ST_EMPTY;
				else iv = level_at(r.point_time);
			end
			MODE_AREA: begin
				if (table_count == 0) o.status = ST_EMPTY;
				else o.area_result = area_between(r.point_time, r.end_time);
			end
			default: o.status = ST_OK;
		endcase
		o.interp_value = iv[31:0];
		o.points_held = table_count[8:0];
		return o;
	endfunction

	function automatic void add_row(logic [1:0] mode, bit [31:0] t, bit [31:0] v, bit [31:0] te,
			bit typed, logic [1:0] st, bit [31:0] iv, bit [63:0] ar, bit [8:0] cnt);
		row_t w;
		w.r = '{mode: mode, point_time: t, point_value: v, end_time: te};
		w.typed = typed;
		w.e = '{status: st, interp_value: iv, area_result: ar, points_held: cnt};
		rows.push_back(w);
	endfunction

	function automatic int unsigned gap_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic bit [31:0] near_time();
		int unsigned i;
		bit [31:0] t;
		if (table_count == 0 || $urandom_range(0, 9) == 0) return $urandom;
		i = $urandom_range(1, table_count);
		t = t_at(i);
		case ($urandom_range(0, 3))
			0: return t;
			1: return t + $urandom_range(0, 3) - 1;
			2: return (i < table_count) ? t + (t_at(i + 1) - t) / 2 : t + 32'd17;
			default: return t + $urandom_range(0, 500) - 250;
		endcase
	endfunction

	function automatic req_t random_req();
		req_t r;
		int unsigned p, i, j;
		r.mode = MODE_IGNORED;
		r.point_time = $urandom;
		r.point_value = $urandom;
		r.end_time = $urandom;
		p = $urandom_range(0, 99);
		if (p < 40) begin
			r.mode = MODE_INSERT;
			if ($urandom_range(0, 4) == 0) r.point_time = near_time();
			if ($urandom_range(0, 2) == 0) r.point_value = $urandom_range(0, 2000) - 1000;
		end else if (p < 70) begin
			r.mode = MODE_VALUE;
			r.point_time = near_time();
		end else if (p < 96) begin
			r.mode = MODE_AREA;
			if (table_count > 0 && $urandom_range(0, 49) != 0) begin
				i = $urandom_range(1, table_count);
				j = i + $urandom_range(0, 5);
				if (j > table_count) j = table_count;
				r.point_time = t_at(i) + $urandom_range(0, 20) - 10;
				r.end_time = t_at(j) + $urandom_range(0, 20) - 10;
				if ($urandom_range(0, 7) == 0) begin
					r.point_time = r.end_time;
					r.end_time = t_at(i);
				end
			end
		end
		return r;
	endfunction

	task automatic send_req(req_t r, bit typed, rsp_t e);
		rsp_t p;
		int unsigned g;
		g = gap_len();
		if (g > 0) begin
			req_if.valid = 1'b0;
			repeat (g) @(negedge clk);
		end
		req_if.valid = 1'b1;
		req_if.data = r;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		p = predict_rsp(r);
		expected_rsps.push_back(typed ? e : p);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
			if (rsp_if.valid && rsp_if.ready) begin
				results_seen++;
				if (expected_rsps.size() == 0) begin
					$error("response with nothing expected");
					mismatches++;
				end else begin
					exp_rsp = expected_rsps.pop_front();
					if (rsp_if.data.status !== exp_rsp.status) begin
						$error("status: expected %0d actual %0d", exp_rsp.status, rsp_if.data.status);
						mismatches++;
					end
					if (rsp_if.data.interp_value !== exp_rsp.interp_value) begin
						$error("interp_value: expected %0d actual %0d",
							exp_rsp.interp_value, rsp_if.data.interp_value);
						mismatches++;
					end
					if (rsp_if.data.area_result !== exp_rsp.area_result) begin
						$error("area_result: expected %0d actual %0d",
							exp_rsp.area_result, rsp_if.data.area_result);
						mismatches++;
					end
					if (rsp_if.data.points_held !== exp_rsp.points_held) begin
						$error("points_held: expected %0d actual %0d",
							exp_rsp.points_held, rsp_if.data.points_held);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		int unsigned g;
		bit held;
		held = 1'b0;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && results_seen >= 300) begin
				held = 1'b1;
				rsp_if.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			g = gap_len();
			if (g > 0) begin
				rsp_if.ready = 1'b0;
				repeat (g) @(negedge clk);
			end
			rsp_if.ready = 1'b1;
			@(posedge clk);
			while (!rsp_if.valid) @(posedge clk);
		end
	end

	initial begin
		rsp_t none;
		table_count = 0;
		none = '0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		arst_n = 1'b0;

		add_row(MODE_VALUE, 0, 0, 0, 1, ST_EMPTY, 0, 0, 0);
		add_row(MODE_AREA, 0, 0, '1, 1, ST_EMPTY, 0, 0, 0);
		add_row(MODE_IGNORED, '1, '1, '1, 1, ST_OK, 0, 0, 0);
		add_row(MODE_INSERT, 0, 32'h8000_0000, 0, 1, ST_OK, 0, 0, 1);
		add_row(MODE_INSERT, 0, 32'h7FFF_FFFF, '1, 1, ST_DUP, 0, 0, 1);
		add_row(MODE_VALUE, '1, 0, 0, 1, ST_OK, 32'h8000_0000, 0, 1);
		add_row(MODE_AREA, 0, 0, '1, 0, ST_OK, 0, 0, 0);
		add_row(MODE_AREA, '1, 0, 0, 0, ST_OK, 0, 0, 0);
		add_row(MODE_INSERT, '1, 32'h7FFF_FFFF, 0, 1, ST_OK, 0, 0, 2);
		add_row(MODE_VALUE, 32'h8000_0000, 0, 0, 0, ST_OK, 0, 0, 0);
		add_row(MODE_VALUE, '1, 0, 0, 1, ST_OK, 32'h7FFF_FFFF, 0, 2);
		add_row(MODE_AREA, 0, 0, '1, 0, ST_OK, 0, 0, 0);
		add_row(MODE_INSERT, 1000, 0, 0, 1, ST_OK, 0, 0, 3);
		add_row(MODE_VALUE, 1000, 0, 0, 1, ST_OK, 0, 0, 3);
		add_row(MODE_VALUE, 999, 0, 0, 0, ST_OK, 0, 0, 0);
		add_row(MODE_AREA, 500, 0, 1500, 0, ST_OK, 0, 0, 0);
		add_row(MODE_AREA, 1500, 0, 500, 0, ST_OK, 0, 0, 0);
		add_row(MODE_AREA, 5, 0, 5, 0, ST_OK, 0, 0, 0);
		add_row(MODE_INSERT, 7, '1, 0, 0, ST_OK, 0, 0, 0);
		add_row(MODE_AREA, 0, 0, 2000, 0, ST_OK, 0, 0, 0);
		add_row(MODE_INSERT, 2000, 32'h7FFF_FFFF, 0, 0, ST_OK, 0, 0, 0);
		add_row(MODE_AREA, '1, 0, 3, 0, ST_OK, 0, 0, 0);

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		foreach (rows[k]) send_req(rows[k].r, rows[k].typed, rows[k].e);

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == 700) begin
				req_if.valid = 1'b0;
				while (expected_rsps.size() != 0) @(negedge clk);
			end
			send_req(random_req(), 0, none);
		end
		req_if.valid = 1'b0;

		while (expected_rsps.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+sv
sv/sbti_pkg.sv
sv/sbti_if.sv
sv/sbti_arith.sv
sv/sbti_store.sv
sv/sorted_breakpoint_table_interp.sv
bench/tb_top.sv
